/* hw/rtl/chacha20_stream_xor_macros.svh */
// Assertion shorthands shared by the FIFO, core and back-end RTL files.
// Every check is sampled on the rising edge of clk and is off while rst is high.
`ifndef CHACHA20_STREAM_XOR_MACROS_SVH
`define CHACHA20_STREAM_XOR_MACROS_SVH

// Same-cycle implication
`define CC20_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CC20_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/cc20_pkg.sv */
package cc20_pkg;

  // Fixed block layout
  localparam int BLOCK_BYTES = 64;
  localparam int OFF_W       = $clog2(BLOCK_BYTES);
  localparam int NUM_WORDS   = 16;
  localparam int WIDX_W      = $clog2(NUM_WORDS);

  // Rounds: 10 double rounds, each quarter round split into two halves
  localparam int ROUND_STEPS = 40;
  localparam int STEP_W      = $clog2(ROUND_STEPS);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] SIGMA0    = 32'h6170_7865;
  localparam logic [31:0] SIGMA1    = 32'h3320_646e;
  localparam logic [31:0] SIGMA2    = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3    = 32'h6b20_6574;
  localparam logic [31:0] FIRST_CTR = 32'd1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_HIGH = 3'd5;

  typedef logic [NUM_WORDS-1:0][31:0] block_t;

  typedef struct packed {
    logic [63:0] key_part_0;
    logic [63:0] key_part_1;
    logic [63:0] key_part_2;
    logic [63:0] key_part_3;
    logic [63:0] nonce_low;
    logic [31:0] nonce_high;
  } cfg_t;

  // One classified byte on its way from front to back
  typedef struct packed {
    logic [7:0]       data;
    logic             need;   // first byte of a fresh keystream block
    logic [31:0]      ctr;    // block counter of that block
    logic [OFF_W-1:0] off;    // byte position inside the block
  } entry_t;

  // Core status seen by the back end
  typedef struct packed {
    logic        active;  // holds or builds the block for ctr
    logic        done;    // block for ctr is final
    logic [31:0] ctr;
  } core_stat_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } quad_t;

  // Half of a quarter round: rotations 16/12 first, 8/7 second
  function automatic quad_t qr_half(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                    logic [31:0] d, logic second);
    quad_t       q;
    logic [31:0] x;
    logic [31:0] y;
    q.a = a + b;
    x   = d ^ q.a;
    q.d = second ? {x[23:0], x[31:24]} : {x[15:0], x[31:16]};
    q.c = c + q.d;
    y   = b ^ q.c;
    q.b = second ? {y[24:0], y[31:25]} : {y[19:0], y[31:20]};
    return q;
  endfunction

  // Input state of a block
  function automatic block_t init_block(cfg_t c, logic [31:0] ctr);
    block_t s;
    s[0]  = SIGMA0;
    s[1]  = SIGMA1;
    s[2]  = SIGMA2;
    s[3]  = SIGMA3;
    s[4]  = c.key_part_0[31:0];
    s[5]  = c.key_part_0[63:32];
    s[6]  = c.key_part_1[31:0];
    s[7]  = c.key_part_1[63:32];
    s[8]  = c.key_part_2[31:0];
    s[9]  = c.key_part_2[63:32];
    s[10] = c.key_part_3[31:0];
    s[11] = c.key_part_3[63:32];
    s[12] = ctr;
    s[13] = c.nonce_low[31:0];
    s[14] = c.nonce_low[63:32];
    s[15] = c.nonce_high;
    return s;
  endfunction

endpackage

/* hw/rtl/cc20_front.sv */
module cc20_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [7:0]       data_byte,
  input  logic             start_message,
  input  logic             q_full,
  output logic             q_push,
  output cc20_pkg::entry_t q_entry
);
  import cc20_pkg::*;

  logic [31:0]      counter;
  logic [OFF_W-1:0] offset;
  logic             blk_ready;

  logic [31:0]      eff_ctr;
  logic [OFF_W-1:0] eff_off;
  logic [OFF_W-1:0] off_inc;
  logic             need;

  // A start mark restarts the message before the byte is classified
  always_comb begin
    eff_ctr = start_message ? FIRST_CTR : counter;
    eff_off = start_message ? '0 : offset;
    need    = start_message ? 1'b1 : !blk_ready;
    off_inc = eff_off + 1'b1;
    q_push  = push && !q_full;
    q_entry = '{data: data_byte, need: need, ctr: eff_ctr, off: eff_off};
  end

  // Message position tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      counter   <= FIRST_CTR;
      offset    <= '0;
      blk_ready <= 1'b0;
    end else if (q_push) begin
      counter   <= need ? eff_ctr + 32'd1 : eff_ctr;
      offset    <= off_inc;
      blk_ready <= (off_inc != '0);
    end
  end

endmodule

/* hw/rtl/cc20_fifo.sv */
`include "chacha20_stream_xor_macros.svh"

module cc20_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cc20_pkg::entry_t din,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output cc20_pkg::entry_t dout
);
  import cc20_pkg::*;

  entry_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign dout  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `CC20_ASSERT(a_no_overflow, push, !full, "push into full queue")
  `CC20_ASSERT(a_no_underflow, pop, valid, "pop from empty queue")
  `CC20_ASSERT_NEXT(a_count_hold, !push && !pop, count == $past(count), "queue level moved")

endmodule

/* hw/rtl/cc20_core.sv */
`include "chacha20_stream_xor_macros.svh"

module cc20_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 kick,
  input  logic [31:0]          kick_ctr,
  input  logic                 abort,
  input  cc20_pkg::cfg_t       cfg,
  output cc20_pkg::core_stat_t stat,
  output cc20_pkg::block_t     words
);
  import cc20_pkg::*;

  typedef enum logic [3:0] {
    CORE_IDLE = 4'b0001,
    CORE_RUN  = 4'b0010,
    CORE_ADD  = 4'b0100,
    CORE_DONE = 4'b1000
  } core_state_t;

  core_state_t       state;
  logic [STEP_W-1:0] step;
  logic [31:0]       ctr;
  block_t            w;
  block_t            rnd;
  block_t            kick_init;
  block_t            add_init;
  quad_t             q;
  logic [WIDX_W-1:0] ia;
  logic [WIDX_W-1:0] ib;
  logic [WIDX_W-1:0] ic;
  logic [WIDX_W-1:0] id;
  logic              second;
  logic              diag;

  assign second    = step[0];
  assign diag      = step[1];
  assign kick_init = init_block(cfg, kick_ctr);
  assign add_init  = init_block(cfg, ctr);

  assign stat.active = (state != CORE_IDLE);
  assign stat.done   = (state == CORE_DONE);
  assign stat.ctr    = ctr;
  assign words       = w;

  // One half round step over the four independent quarter rounds
  always_comb begin
    rnd = w;
    ia  = '0;
    ib  = '0;
    ic  = '0;
    id  = '0;
    q   = '0;
    for (int i = 0; i < 4; i++) begin
      ia = WIDX_W'(i);
      ib = diag ? WIDX_W'(4 + ((i + 1) & 3)) : WIDX_W'(4 + i);
      ic = diag ? WIDX_W'(8 + ((i + 2) & 3)) : WIDX_W'(8 + i);
      id = diag ? WIDX_W'(12 + ((i + 3) & 3)) : WIDX_W'(12 + i);
      q  = qr_half(w[ia], w[ib], w[ic], w[id], second);
      rnd[ia] = q.a;
      rnd[ib] = q.b;
      rnd[ic] = q.c;
      rnd[id] = q.d;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CORE_IDLE;
      step  <= '0;
    end else if (abort) begin
      state <= CORE_IDLE;
    end else if (kick) begin
      state <= CORE_RUN;
      step  <= '0;
    end else begin
      unique case (state)
        CORE_RUN: begin
          step <= step + 1'b1;
          if (step == STEP_W'(ROUND_STEPS - 1)) begin
            state <= CORE_ADD;
          end
        end
        CORE_ADD:  state <= CORE_DONE;
        CORE_IDLE: state <= CORE_IDLE;
        CORE_DONE: state <= CORE_DONE;
        default:   state <= CORE_IDLE;
      endcase
    end
  end

  // Working state; final add of the input state after the last step
  always_ff @(posedge clk) begin
    if (kick) begin
      ctr <= kick_ctr;
      w   <= kick_init;
    end else if (state == CORE_RUN) begin
      w <= rnd;
    end else if (state == CORE_ADD) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        w[i] <= w[i] + add_init[i];
      end
    end
  end

  `CC20_ASSERT(a_step_range, state == CORE_RUN, step < STEP_W'(ROUND_STEPS),
               "round step out of range")

endmodule

/* hw/rtl/cc20_back.sv */
`include "chacha20_stream_xor_macros.svh"

module cc20_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  cc20_pkg::entry_t     head,
  output logic                 head_pop,
  input  cc20_pkg::core_stat_t stat,
  input  cc20_pkg::block_t     words,
  output logic                 kick,
  output logic [31:0]          kick_ctr,
  input  logic                 pop,
  output logic                 out_valid,
  output logic [7:0]           out_byte
);
  import cc20_pkg::*;

  block_t      cur;
  block_t      src;
  logic [31:0] wsel;
  logic [7:0]  ks;
  logic        out_can;
  logic        match;
  logic        fire;

  // Pick the keystream byte: a fresh block comes straight from the core
  always_comb begin
    out_can  = !out_valid || pop;
    match    = stat.active && (stat.ctr == head.ctr);
    fire     = head_valid && out_can && (!head.need || (match && stat.done));
    src      = head.need ? words : cur;
    wsel     = src[head.off[OFF_W-1:2]];
    ks       = wsel[{head.off[1:0], 3'b000} +: 8];
    head_pop = fire;
    // Start the wanted block, or prefetch the following one once taken
    kick     = (fire && head.need) || (head_valid && head.need && !match);
    kick_ctr = fire ? head.ctr + 32'd1 : head.ctr;
  end

  // Current keystream block and output byte
  always_ff @(posedge clk) begin
    if (fire && head.need) begin
      cur <= words;
    end
    if (fire) begin
      out_byte <= head.data ^ ks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  `CC20_ASSERT(a_need_at_block_start, head_valid && head.need, head.off == '0,
               "new block requested mid-block")

endmodule

/* hw/rtl/chacha20_stream_xor.sv */
// Path: an accepted byte passes the queue and the output register when its block is on
// hand; a byte opening a block not yet built also waits for 40 half-round steps of the
// shared round unit, one final add, load and output stages. Throughput: one byte per
// cycle without pop stalls or block waits; the next block is built in the background
// while the current 64 bytes stream. A start mark or a config write costs one rebuild.
// Reset: synchronous, clears queues, message position (counter 1) and key/nonce to 0.
module chacha20_stream_xor (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [7:0]                       data_byte,
  input  logic                             start_message,
  output logic                             empty,
  input  logic                             pop,
  output logic [7:0]                       result_byte,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cc20_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                      cfg_data
);
  import cc20_pkg::*;

  cfg_t       cfg;
  logic       q_push;
  entry_t     q_in;
  logic       q_pop;
  logic       q_valid;
  entry_t     q_head;
  core_stat_t stat;
  block_t     words;
  logic       kick;
  logic [31:0] kick_ctr;
  logic       out_valid;
  logic       cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign empty     = !out_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_KEY_PART_0: cfg.key_part_0 <= cfg_data;
        REG_KEY_PART_1: cfg.key_part_1 <= cfg_data;
        REG_KEY_PART_2: cfg.key_part_2 <= cfg_data;
        REG_KEY_PART_3: cfg.key_part_3 <= cfg_data;
        REG_NONCE_LOW:  cfg.nonce_low  <= cfg_data;
        REG_NONCE_HIGH: cfg.nonce_high <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  cc20_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .data_byte     (data_byte),
    .start_message (start_message),
    .q_full        (full),
    .q_push        (q_push),
    .q_entry       (q_in)
  );

  cc20_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_head)
  );

  // Any config write drops a block built or prefetched with old key material
  cc20_core u_core (
    .clk      (clk),
    .rst      (rst),
    .kick     (kick),
    .kick_ctr (kick_ctr),
    .abort    (cfg_wr),
    .cfg      (cfg),
    .stat     (stat),
    .words    (words)
  );

  cc20_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head       (q_head),
    .head_pop   (q_pop),
    .stat       (stat),
    .words      (words),
    .kick       (kick),
    .kick_ctr   (kick_ctr),
    .pop        (pop && out_valid),
    .out_valid  (out_valid),
    .out_byte   (result_byte)
  );

endmodule

/* sim/tb_chacha20_stream_xor.sv */
module tb_chacha20_stream_xor;
  import cc20_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int BUILD_CYCLES = 60;   // block rebuild plus output stages, with margin
  localparam int PHASES       = 6;
  localparam int PHASE_BYTES  = 80;

  // Indexes past the last register: the block must ignore them
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  // Keystream predictor plus queue of expected output bytes
  class cipher_board;
    logic [63:0] key_reg[4];
    logic [63:0] nonce_lo;
    logic [31:0] nonce_hi;
    logic [31:0] blk_ctr;
    logic [7:0]  ks_buf[BLOCK_BYTES];
    logic [5:0]  ks_pos;
    bit          ks_valid;
    logic [31:0] mix[16];
    logic [7:0]  expected_bytes[$];
    int          errors;

    function new();
      foreach (key_reg[i]) key_reg[i] = '0;
      nonce_lo = '0;
      nonce_hi = '0;
      blk_ctr  = 32'd1;
      ks_pos   = '0;
      ks_valid = 0;
      errors   = 0;
    endfunction

    function logic [31:0] rotl(logic [31:0] v, int s);
      return (v << s) | (v >> (32 - s));
    endfunction

    function void quarter(int a, int b, int c, int d);
      mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
      mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
      mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
      mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
    endfunction

    // 20 rounds on the input state, add back, serialize little-endian
    function void make_keystream();
      logic [31:0] seed[16];
      logic [31:0] w;
      seed[0]  = SIGMA0;
      seed[1]  = SIGMA1;
      seed[2]  = SIGMA2;
      seed[3]  = SIGMA3;
      for (int k = 0; k < 4; k++) begin
        seed[4 + 2*k] = key_reg[k][31:0];
        seed[5 + 2*k] = key_reg[k][63:32];
      end
      seed[12] = blk_ctr;
      seed[13] = nonce_lo[31:0];
      seed[14] = nonce_lo[63:32];
      seed[15] = nonce_hi;
      mix = seed;
      for (int r = 0; r < 10; r++) begin
        quarter(0, 4, 8, 12);
        quarter(1, 5, 9, 13);
        quarter(2, 6, 10, 14);
        quarter(3, 7, 11, 15);
        quarter(0, 5, 10, 15);
        quarter(1, 6, 11, 12);
        quarter(2, 7, 8, 13);
        quarter(3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) begin
        w = mix[i] + seed[i];
        for (int b = 0; b < 4; b++) ks_buf[4*i + b] = w[8*b +: 8];
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] d);
      case (idx)
        REG_KEY_PART_0: key_reg[0] = d;
        REG_KEY_PART_1: key_reg[1] = d;
        REG_KEY_PART_2: key_reg[2] = d;
        REG_KEY_PART_3: key_reg[3] = d;
        REG_NONCE_LOW:  nonce_lo   = d;
        REG_NONCE_HIGH: nonce_hi   = d[31:0];
        default: ;
      endcase
    endfunction

    // Accepted input transaction: advance stream position, queue expected byte
    function void accept_byte(logic [7:0] d, logic s);
      if (s) begin
        blk_ctr  = 32'd1;
        ks_pos   = '0;
        ks_valid = 0;
      end
      if (!ks_valid) begin
        make_keystream();
        blk_ctr  = blk_ctr + 32'd1;
        ks_valid = 1;
      end
      expected_bytes.push_back(d ^ ks_buf[ks_pos]);
      ks_pos = ks_pos + 6'd1;
      if (ks_pos == 6'd0) ks_valid = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("%0t: %s", $time, msg);
    endtask

    task check_byte(logic [7:0] got);
      logic [7:0] want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("result_byte %02h with no transaction pending", got));
      end else begin
        want = expected_bytes.pop_front();
        if (got !== want)
          report($sformatf("result_byte %02h, expected %02h", got, want));
      end
    endtask

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic [7:0]           data_byte = '0;
  logic                 start_message = 1'b0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [7:0]           result_byte;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_KEY_PART_0;
  logic [63:0]          cfg_data = '0;

  cipher_board board = new();
  bit          tx_burst = 0;
  bit          rx_burst = 0;
  int          cycle_count;

  chacha20_stream_xor DUT (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .data_byte     (data_byte),
    .start_message (start_message),
    .empty         (empty),
    .pop           (pop),
    .result_byte   (result_byte),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Monitor: every transaction seen at the clock edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
      if (push && !full) board.accept_byte(data_byte, start_message);
      if (pop && !empty) board.check_byte(result_byte);
    end
  end

  // Input side: random gap, then hold push until accepted
  task automatic send_byte(logic [7:0] d, logic s);
    int gap;
    if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push          <= 1'b1;
    data_byte     <= d;
    start_message <= s;
    do @(posedge clk); while (full);
  endtask

  // Result side: random stalls with stretches of steady popping
  task automatic pop_results();
    int gap;
    forever begin
      if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  endtask

  // Leaves cfg_valid high; caller lowers it after the last write
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_config(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                             logic [63:0] k3, logic [63:0] nl, logic [63:0] nh);
    cfg_write(REG_KEY_PART_0, k0);
    cfg_write(REG_KEY_PART_1, k1);
    cfg_write(REG_KEY_PART_2, k2);
    cfg_write(REG_KEY_PART_3, k3);
    cfg_write(REG_NONCE_LOW, nl);
    cfg_write(REG_NONCE_HIGH, nh);
    cfg_valid <= 1'b0;
  endtask

  // Stop sending, let every expected byte arrive and the background build settle
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (BUILD_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // One message; a stray start mark now and then restarts it
  task automatic send_message(int len, logic first_start);
    logic s;
    for (int i = 0; i < len; i++) begin
      s = (i == 0) ? first_start : ($urandom_range(0, 59) == 0);
      send_byte(8'($urandom_range(0, 255)), s);
    end
  endtask

  initial begin
    int                   sent;
    int                   len;
    int                   r;
    logic [CFG_IDX_W-1:0] idx;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    fork
      pop_results();
    join_none

    // Unmarked bytes after reset, zero key; then restarts inside a block
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h5a, 1'b1);
    wait_drained();

    // All-ones key and nonce; writes to unused indexes change nothing
    cfg_write(REG_KEY_PART_0, '1);
    cfg_write(REG_KEY_PART_1, '1);
    cfg_write(REG_KEY_PART_2, '1);
    cfg_write(REG_KEY_PART_3, '1);
    cfg_write(REG_NONCE_LOW, '1);
    cfg_write(REG_NONCE_HIGH, '1);
    cfg_write(REG_UNUSED_LO, '0);
    cfg_write(REG_UNUSED_HI, 64'h0123_4567_89ab_cdef);
    cfg_valid <= 1'b0;
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'ha5, 1'b0);
    wait_drained();

    // Key change inside a block: the current block stays in use
    cfg_write(REG_KEY_PART_0, 64'h0706_0504_0302_0100);
    cfg_valid <= 1'b0;
    send_byte(8'h3c, 1'b0);
    send_byte(8'hc3, 1'b0);
    wait_drained();

    // Standard test key and nonce
    load_config(64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908,
                64'h1716_1514_1312_1110, 64'h1f1e_1d1c_1b1a_1918,
                64'h4a00_0000_0900_0000, 64'h0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'hfe, 1'b0);
    wait_drained();

    // Random phases: well-formed messages, some unmarked continuations
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       load_config('0, '0, '0, '0, '0, '0);
        1:       load_config('1, '1, '1, '1, '1, '1);
        default: load_config(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
      endcase
      sent = 0;
      while (sent < PHASE_BYTES) begin
        r = $urandom_range(0, 9);
        if (r == 0)      len = BLOCK_BYTES;
        else if (r == 1) len = 2 * BLOCK_BYTES;
        else             len = $urandom_range(1, 90);
        send_message(len, $urandom_range(0, 9) != 0);
        sent += len;
        // Now and then the sender holds off until all results are back, sometimes rekeys mid-stream
        if ($urandom_range(0, 3) == 0) begin
          wait_drained();
          if ($urandom_range(0, 1) == 0) begin
            idx = CFG_IDX_W'($urandom_range(0, 7));
            cfg_write(idx, rand64());
            cfg_valid <= 1'b0;
          end
        end
      end
      wait_drained();
    end

    if (board.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
